// ----- rtl/core/swrm_pkg.sv -----
// swrm_pkg: shared types and constants for the sliding window rate meter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package swrm_pkg;

  localparam int SAMPLE_W = 24;
  localparam int TIME_W   = 32;
  localparam int AGE_W    = 16;
  localparam int RATE_W   = 50;
  localparam int SCALE_W  = 18;

  localparam logic [AGE_W-1:0]   AGE_LIMIT_RESET = 16'd7000;
  // 1000 per second times 256 for the q8 fraction
  localparam logic [SCALE_W-1:0] RATE_SCALE      = 18'd256000;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_IVL_RD,
    ST_IVL_CHK,
    ST_SUM,
    ST_SUM_END,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    RD_WS,
    RD_NEXT,
    RD_SUM
  } rd_sel_t;

  typedef struct packed {
    logic    add_we;
    logic    load_query;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    walk_clear;
    logic    ivl_load;
    logic    sum_issue;
    logic    clear_ring;
    logic    mul_load;
    logic    div_start;
    logic    res_load;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic stale;
    logic ivl_zero;
    logic sum_last;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/core/swrm_if.sv -----
// swrm_in_if and swrm_out_if: valid/ready channels of the rate meter
// depends on nothing; payload widths match swrm_pkg
`timescale 1ns / 1ps

interface swrm_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [23:0] sample_value;
  logic [31:0] now_ms;

  modport source (output valid, output mode, output sample_value, output now_ms,
                  input ready);
  modport sink   (input valid, input mode, input sample_value, input now_ms,
                  output ready);
endinterface

interface swrm_out_if;
  logic        valid;
  logic        ready;
  logic [49:0] rate_q8;
  logic        no_data;

  modport source (output valid, output rate_q8, output no_data, input ready);
  modport sink   (input valid, input rate_q8, input no_data, output ready);
endinterface

// ----- rtl/core/sliding_window_rate_meter.sv -----
// An add item (mode 0) is taken while the sequencer is idle and writes its
// sample and time into the ring; adds keep flowing while a query result waits
// at the output. A query (mode 1) walks and clears the stale entries, sums the
// ring over the single ring read port, then scales the sum and divides it in
// a bit-serial divider with one step per bit of the scaled sum, whose width is
// P = 42 + clog2(RING_DEPTH). A query that finds a zero interval returns
// no_data. Queries are handled one at a time; the ring is cleared at a query
// that returns a rate by dropping per-entry valid bits, so no clearing pass
// is needed.
// depends on swrm_pkg, swrm_if, swrm_ctrl, swrm_datapath
`timescale 1ns / 1ps

module sliding_window_rate_meter import swrm_pkg::*; #(
  parameter int RING_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [AGE_W-1:0] cfg_wdata,
  swrm_in_if.sink          in_item,
  swrm_out_if.source       out_item
);

  cmd_t    cmd;
  status_t status;

  swrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_item.valid),
    .in_mode  (in_item.mode),
    .in_ready (in_item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  swrm_datapath #(
    .DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_sample (in_item.sample_value),
    .in_now    (in_item.now_ms),
    .out_ready (out_item.ready),
    .out_valid (out_item.valid),
    .rate_q8   (out_item.rate_q8),
    .no_data   (out_item.no_data),
    .cmd       (cmd),
    .status    (status)
  );

  // a result is only loaded into a free output slot
  a_res_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> status.out_free)
    else $error("result loaded while output slot occupied");

  a_div_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("divider restarted while busy");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_clear |-> !status.walk_done)
    else $error("stale walk ran past the ring depth");

  a_nodata_zero_rate: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> (!out_item.no_data || out_item.rate_q8 == '0))
    else $error("no_data result carries a nonzero rate");

endmodule

// ----- rtl/core/swrm_div.sv -----
// swrm_div: restoring divider, one quotient bit per cycle
// depends on swrm_pkg for the time width
`timescale 1ns / 1ps

module swrm_div import swrm_pkg::*; #(
  parameter int N = 46
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [N-1:0]      dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              busy,
  output logic [N-1:0]      quotient
);

  localparam int CNT_W = $clog2(N + 1);

  logic [N-1:0]      qr;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [TIME_W:0]   rem_sh;
  logic              ge;
  logic [TIME_W:0]   diff;

  assign rem_sh   = {rem, qr[N-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = qr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(N);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      // remainder stays below the divisor, so it fits the time width
      rem <= ge ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
      qr  <= {qr[N-2:0], ge};
    end
  end

endmodule

// ----- rtl/core/swrm_datapath.sv -----
// swrm_datapath: sample/time ring, pointer, stale check, sum, scale, divide
// depends on swrm_pkg and swrm_div; driven by swrm_ctrl commands
`timescale 1ns / 1ps

module swrm_datapath import swrm_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [AGE_W-1:0]    cfg_wdata,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic [TIME_W-1:0]   in_now,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [RATE_W-1:0]   rate_q8,
  output logic                no_data,
  input  cmd_t                cmd,
  output status_t             status
);

  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int SUM_W  = SAMPLE_W + AW;
  localparam int PROD_W = SUM_W + SCALE_W;

  logic [SAMPLE_W-1:0] sample_mem [DEPTH];
  logic [TIME_W-1:0]   time_mem [DEPTH];
  logic [DEPTH-1:0]    valid;

  logic [AW-1:0]       ws;
  logic [AW-1:0]       ws_inc;
  logic [AGE_W-1:0]    age_limit;
  logic [TIME_W-1:0]   now_q;
  logic [TIME_W-1:0]   base_time;
  logic [CW-1:0]       walk_cnt;
  logic [AW-1:0]       sum_idx;
  logic                acc_en_q;
  logic [SUM_W-1:0]    acc;
  logic [TIME_W-1:0]   interval_q;
  logic                nodata_q;
  logic [PROD_W-1:0]   prod;

  logic [AW-1:0]       rd_addr;
  logic [SAMPLE_W-1:0] rd_sample_q;
  logic [TIME_W-1:0]   rd_time_q;
  logic                rd_valid_q;
  logic [SAMPLE_W-1:0] entry_sample;
  logic [TIME_W-1:0]   entry_time;
  logic [TIME_W-1:0]   age_diff;

  logic                wr_en;
  logic [SAMPLE_W-1:0] wr_sample;
  logic [TIME_W-1:0]   wr_time;

  logic                div_busy;
  logic [PROD_W-1:0]   quot;

  assign ws_inc = (ws == AW'(DEPTH - 1)) ? '0 : ws + 1'b1;

  always_comb begin
    case (cmd.rd_sel)
      RD_WS:   rd_addr = ws;
      RD_NEXT: rd_addr = ws_inc;
      RD_SUM:  rd_addr = sum_idx;
      default: rd_addr = ws;
    endcase
  end

  // entries not written since the last full clear read as zero at base_time
  assign entry_sample = rd_valid_q ? rd_sample_q : '0;
  assign entry_time   = rd_valid_q ? rd_time_q : base_time;
  assign age_diff     = now_q - entry_time;

  assign wr_en     = cmd.add_we | cmd.walk_clear;
  assign wr_sample = cmd.add_we ? in_sample : '0;
  assign wr_time   = cmd.add_we ? in_now : now_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sample_mem[ws] <= wr_sample;
      time_mem[ws]   <= wr_time;
    end
    if (cmd.rd_en) begin
      rd_sample_q <= sample_mem[rd_addr];
      rd_time_q   <= time_mem[rd_addr];
      rd_valid_q  <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      ws        <= '0;
      base_time <= '0;
      age_limit <= AGE_LIMIT_RESET;
      acc_en_q  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        age_limit <= cfg_wdata;
      end
      if (cmd.clear_ring) begin
        valid     <= '0;
        ws        <= '0;
        base_time <= now_q;
      end else if (wr_en) begin
        valid[ws] <= 1'b1;
        ws        <= ws_inc;
      end
      acc_en_q <= cmd.sum_issue;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      now_q <= in_now;
    end
    if (cmd.load_query) begin
      walk_cnt <= '0;
    end else if (cmd.walk_clear) begin
      walk_cnt <= walk_cnt + 1'b1;
    end
    if (cmd.load_query) begin
      sum_idx <= '0;
    end else if (cmd.sum_issue) begin
      sum_idx <= sum_idx + 1'b1;
    end
    // read data arrives in the cycle after its address is issued
    if (cmd.load_query) begin
      acc <= '0;
    end else if (acc_en_q) begin
      acc <= acc + SUM_W'(entry_sample);
    end
    if (cmd.ivl_load) begin
      interval_q <= age_diff;
      nodata_q   <= (age_diff == '0);
    end
    if (cmd.mul_load) begin
      prod <= PROD_W'(acc) * PROD_W'(RATE_SCALE);
    end
    if (cmd.res_load) begin
      rate_q8 <= nodata_q ? '0 : RATE_W'(quot);
      no_data <= nodata_q;
    end
  end

  swrm_div #(
    .N (PROD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (interval_q),
    .busy     (div_busy),
    .quotient (quot)
  );

  always_comb begin
    status.walk_done = (walk_cnt == CW'(DEPTH));
    status.stale     = (age_diff > TIME_W'(age_limit));
    status.ivl_zero  = (age_diff == '0);
    status.sum_last  = (sum_idx == AW'(DEPTH - 1));
    status.div_busy  = div_busy;
    status.out_free  = !out_valid || out_ready;
  end

endmodule

// ----- rtl/core/swrm_ctrl.sv -----
// swrm_ctrl: sequencer for add and query items
// depends on swrm_pkg; issues commands to swrm_datapath
`timescale 1ns / 1ps

module swrm_ctrl import swrm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_mode,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_mode == MODE_QUERY) begin
          state_next = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        state_next = status.walk_done ? ST_IVL_RD : ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        state_next = status.stale ? ST_WALK_RD : ST_IVL_RD;
      end
      ST_IVL_RD:   state_next = ST_IVL_CHK;
      ST_IVL_CHK: begin
        state_next = status.ivl_zero ? ST_RESULT : ST_SUM;
      end
      ST_SUM: begin
        if (status.sum_last) begin
          state_next = ST_SUM_END;
        end
      end
      ST_SUM_END:  state_next = ST_MUL;
      ST_MUL:      state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (!status.div_busy) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.add_we     = (in_mode == MODE_ADD);
          cmd.load_query = (in_mode == MODE_QUERY);
        end
      end
      ST_WALK_RD: begin
        cmd.rd_en  = !status.walk_done;
        cmd.rd_sel = RD_WS;
      end
      ST_WALK_CHK: begin
        cmd.walk_clear = status.stale;
      end
      ST_IVL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_NEXT;
      end
      ST_IVL_CHK: begin
        cmd.ivl_load = 1'b1;
      end
      ST_SUM: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_SUM;
        cmd.sum_issue = 1'b1;
      end
      ST_SUM_END: begin
        cmd.clear_ring = 1'b1;
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
      end
      ST_DIV_WAIT: begin
        cmd = '0;
      end
      ST_RESULT: begin
        cmd.res_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- bench/sliding_window_rate_meter_tb.sv -----
// sliding_window_rate_meter_tb: self-checking bench for the sliding window rate meter
// depends on swrm_pkg, swrm_if and the sliding_window_rate_meter rtl
`timescale 1ns / 1ps

module sliding_window_rate_meter_tb;
  import swrm_pkg::*;

  localparam int RING           = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 120;
  localparam int PHASE_ITEMS    = 204;

  typedef struct {
    logic [RATE_W-1:0] rate_q8;
    logic              no_data;
  } rate_t;

  // mirror of the ring; each accepted query leaves its rate in expected_rates
  class rate_scoreboard;
    logic [SAMPLE_W-1:0] samples [RING];
    logic [TIME_W-1:0]   stamps [RING];
    int unsigned         slot;
    logic [AGE_W-1:0]    age_limit;
    rate_t               expected_rates [$];
    int                  errors;
    int                  n_adds;
    int                  n_queries;
    int                  n_no_data;
    int                  n_results;

    function new();
      foreach (samples[i]) begin
        samples[i] = '0;
        stamps[i]  = '0;
      end
      slot      = 0;
      age_limit = AGE_LIMIT_RESET;
      errors    = 0;
      n_adds    = 0;
      n_queries = 0;
      n_no_data = 0;
      n_results = 0;
    endfunction

    function void set_age_limit(logic [AGE_W-1:0] v);
      age_limit = v;
    endfunction

    function void note_item(logic mode, logic [SAMPLE_W-1:0] sample,
                            logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] age;
      logic [TIME_W-1:0] interval;
      longint unsigned   sum;
      rate_t             res;
      int                i;
      if (mode == MODE_ADD) begin
        samples[slot] = sample;
        stamps[slot]  = now;
        slot          = (slot + 1) % RING;
        n_adds++;
        return;
      end
      n_queries++;
      // stale walk from the write slot, stops at the first fresh entry
      for (i = 0; i < RING; i++) begin
        age = now - stamps[slot];
        if (age <= TIME_W'(age_limit)) break;
        stamps[slot]  = now;
        samples[slot] = '0;
        slot          = (slot + 1) % RING;
      end
      interval = now - stamps[(slot + 1) % RING];
      if (interval == '0) begin
        res.rate_q8 = '0;
        res.no_data = 1'b1;
        n_no_data++;
      end else begin
        sum = 0;
        for (i = 0; i < RING; i++) begin
          sum        += longint'(samples[i]);
          samples[i] = '0;
          stamps[i]  = now;
        end
        slot        = 0;
        res.rate_q8 = RATE_W'((sum * 64'(RATE_SCALE)) / 64'(interval));
        res.no_data = 1'b0;
      end
      expected_rates.push_back(res);
    endfunction

    function void check_result(logic [RATE_W-1:0] rate, logic no_data);
      rate_t want;
      n_results++;
      if (expected_rates.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: rate_q8=%0d no_data=%0b",
                 $time, rate, no_data);
        return;
      end
      want = expected_rates.pop_front();
      if (want.rate_q8 !== rate) begin
        errors++;
        $display("%0t: rate_q8 mismatch: expected %0d, actual %0d",
                 $time, want.rate_q8, rate);
      end
      if (want.no_data !== no_data) begin
        errors++;
        $display("%0t: no_data mismatch: expected %0b, actual %0b",
                 $time, want.no_data, no_data);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [AGE_W-1:0] cfg_wdata;

  swrm_in_if  in_ch ();
  swrm_out_if out_ch ();

  rate_scoreboard    sb = new();
  int                quiet_cycles = 0;
  int                burst_left;
  bit                hold_output;
  logic [TIME_W-1:0] now_base;
  int                n_age_writes;

  sliding_window_rate_meter #(.RING_DEPTH(RING)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  always #2 clk = ~clk;

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_item(in_ch.mode, in_ch.sample_value, in_ch.now_ms);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.rate_q8, out_ch.no_data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL sliding_window_rate_meter");
        $finish;
      end
    end
  end

  // receiver: stretches of steady, patchy or mostly stalled ready, plus one long hold
  initial begin
    int stretch_left;
    int ready_pct;
    stretch_left = 0;
    ready_pct    = 100;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_output) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        if (stretch_left == 0) begin
          stretch_left = $urandom_range(10, 150);
          case ($urandom_range(0, 3))
            0, 1:    ready_pct = 100;
            2:       ready_pct = 60;
            default: ready_pct = 20;
          endcase
        end
        stretch_left--;
        out_ch.ready <= ($urandom_range(0, 99) < ready_pct);
        @(posedge clk);
      end
    end
  end

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(0, 255));
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // offers one item and returns at the edge where it is taken; valid stays high
  task automatic send_item(input logic mode, input logic [SAMPLE_W-1:0] sample,
                           input logic [TIME_W-1:0] now);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.sample_value <= sample;
    in_ch.now_ms       <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // sender pause until every rate is back and the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.expected_rates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_age_limit(input logic [AGE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_age_limit(v);
    n_age_writes++;
  endtask

  task automatic directed_items();
    int k;
    // after reset every stamp is zero, so a query at time zero has no interval
    send_item(MODE_QUERY, '0, 32'd0);
    send_item(MODE_ADD, '1, 32'd10);
    send_item(MODE_ADD, '0, 32'd20);
    send_item(MODE_ADD, 24'd1, 32'd30);
    send_item(MODE_QUERY, '1, 32'd40);
    // same time right after a clear gives no data
    send_item(MODE_QUERY, '0, 32'd40);
    // clock wraps: entries from before look far in the future, so stale
    send_item(MODE_ADD, 24'h800000, 32'hFFFF_FFF0);
    send_item(MODE_QUERY, '0, 32'd5);
    // full ring of the largest samples over a one ms interval
    for (k = 0; k < RING; k++)
      send_item(MODE_ADD, '1, 32'hFFFF_FFFE);
    send_item(MODE_QUERY, '0, 32'hFFFF_FFFF);
    // long silence: the walk clears all sixteen entries
    send_item(MODE_QUERY, '0, 32'd7999);
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned sent;
    int unsigned n_adds;
    int unsigned step_max;
    int unsigned k;
    logic        mode;
    sent     = 0;
    step_max = sb.age_limit / 6 + 2;
    while (sent < target) begin
      if ($urandom_range(0, 15) == 0)
        now_base = $urandom();
      case ($urandom_range(0, 19))
        18, 19: begin
          // query with little or nothing added since the last one
          now_base += $urandom_range(0, 2 * sb.age_limit + 2);
          send_item(MODE_QUERY, random_sample(), now_base);
          sent++;
        end
        15, 16, 17: begin
          mode = ($urandom_range(0, 4) == 0) ? MODE_QUERY : MODE_ADD;
          send_item(mode, SAMPLE_W'($urandom()), $urandom());
          sent++;
        end
        default: begin
          // a window of adds spaced by at most a sixth of the age limit plus two, then the query
          n_adds = $urandom_range(0, 20);
          for (k = 0; k < n_adds; k++) begin
            now_base += $urandom_range(0, step_max);
            send_item(MODE_ADD, random_sample(), now_base);
          end
          case ($urandom_range(0, 3))
            0:       ;
            1:       now_base += $urandom_range(1, step_max);
            2:       now_base += sb.age_limit + $urandom_range(1, 4 * step_max);
            default: now_base += $urandom_range(0, 3 * step_max);
          endcase
          send_item(MODE_QUERY, random_sample(), now_base);
          sent += n_adds + 1;
          if ($urandom_range(0, 4) == 0) begin
            send_item(MODE_QUERY, random_sample(), now_base);
            sent++;
          end
        end
      endcase
    end
  endtask

  initial begin
    logic [AGE_W-1:0] age_plan [7];
    int               p;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= MODE_ADD;
    in_ch.sample_value <= '0;
    in_ch.now_ms       <= '0;
    burst_left   = 0;
    hold_output  = 1'b0;
    n_age_writes = 0;
    now_base     = $urandom();
    age_plan = '{16'd1, 16'd65535, 16'd0, 16'd40, AGE_W'($urandom()),
                 AGE_LIMIT_RESET, AGE_W'($urandom_range(2, 600))};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();
    settle();
    for (p = 0; p < 7; p++) begin
      write_age_limit(age_plan[p]);
      // output held off while queries keep coming, so the input backs up
      if (p == 1)
        hold_output = 1'b1;
      random_phase(PHASE_ITEMS);
      settle();
    end

    $display("covered %0d adds and %0d queries; %0d rates checked, %0d with no data",
             sb.n_adds, sb.n_queries, sb.n_results, sb.n_no_data);
    $display("age limit written %0d times, including 0, 1 and 65535", n_age_writes);
    if (sb.errors == 0 && sb.expected_rates.size() == 0)
      $display("PASS sliding_window_rate_meter");
    else
      $display("FAIL sliding_window_rate_meter");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/swrm_pkg.sv
rtl/core/swrm_if.sv
rtl/core/swrm_div.sv
rtl/core/swrm_datapath.sv
rtl/core/swrm_ctrl.sv
rtl/core/sliding_window_rate_meter.sv
bench/sliding_window_rate_meter_tb.sv
